@@ sv/npcg_pkg.sv @@
// ----------------------------------------------------------------------------
// npcg_pkg
// Shared types, constants and helpers of the color palette generator.
// ----------------------------------------------------------------------------
package npcg_pkg;

   localparam int CODE_W = 6;
   localparam int HUE_W  = 13;
   localparam int SAT_W  = 9;
   localparam int CSR_W  = 13;
   localparam int BAND_W = 32;
   localparam int MAX_ITER = 20;
   localparam int ANGLE_MOD = 5760;

   typedef enum logic [0:0] {
      CSR_HUE_OFFSET = 1'b0,
      CSR_SATURATION = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_HUED  = 2'd0,
      KIND_GRAY0 = 2'd1,
      KIND_GRAYD = 2'd2,
      KIND_BLACK = 2'd3
   } kind_type;

   // Data carried from cell to cell along the rotation chain.
   typedef struct packed {
      logic              flip;
      logic [1:0]        row;
      kind_type          kind;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cell_data_type;

   function automatic logic signed [33:0] atan_entry(input int i);
      logic signed [33:0] t;
      unique case (i)
         0: t = 34'sd536870912;
         1: t = 34'sd316933406;
         2: t = 34'sd167458907;
         3: t = 34'sd85004756;
         4: t = 34'sd42667331;
         5: t = 34'sd21354465;
         6: t = 34'sd10679838;
         7: t = 34'sd5340245;
         8: t = 34'sd2670163;
         9: t = 34'sd1335087;
         10: t = 34'sd667544;
         11: t = 34'sd333772;
         12: t = 34'sd166886;
         13: t = 34'sd83443;
         14: t = 34'sd41721;
         15: t = 34'sd20860;
         16: t = 34'sd10430;
         17: t = 34'sd5215;
         18: t = 34'sd2607;
         19: t = 34'sd1303;
         default: t = 34'sd0;
      endcase
      return t;
   endfunction

   function automatic logic [14:0] luma_value(input kind_type k, input logic [1:0] r);
      logic [14:0] v;
      v = 15'd0;
      unique case (k)
         KIND_GRAY0: begin
            unique case (r)
               2'd0: v = 15'd8192;
               2'd1: v = 15'd12288;
               default: v = 15'd16384;
            endcase
         end
         KIND_GRAYD: begin
            unique case (r)
               2'd0: v = 15'd0;
               2'd1: v = 15'd3932;
               2'd2: v = 15'd7700;
               default: v = 15'd12616;
            endcase
         end
         KIND_HUED: begin
            unique case (r)
               2'd0: v = 15'd4751;
               2'd1: v = 15'd7373;
               2'd2: v = 15'd11960;
               default: v = 15'd14746;
            endcase
         end
         default: v = 15'd0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/npcg_stream_if.sv @@
// ----------------------------------------------------------------------------
// npcg_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface npcg_stream_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/npcg_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// npcg_cordic_cell
// One rotation step of the sine/cosine chain, registered.
// ----------------------------------------------------------------------------
module npcg_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  npcg_pkg::cell_data_type data_in,
   output npcg_pkg::cell_data_type data_out
);
   import npcg_pkg::*;

   cell_data_type data_ff;
   cell_data_type data_in_w;
   logic signed [33:0] dx;
   logic signed [33:0] dy;

   always_comb begin
      dx = data_in.y >>> STEP;
      dy = data_in.x >>> STEP;
      data_in_w = data_in;
      if (!data_in.z[33]) begin
         data_in_w.x = data_in.x - dx;
         data_in_w.y = data_in.y + dy;
         data_in_w.z = data_in.z - atan_entry(STEP);
      end else begin
         data_in_w.x = data_in.x + dx;
         data_in_w.y = data_in.y - dy;
         data_in_w.z = data_in.z + atan_entry(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_w;
      end
   end

   assign data_out = data_ff;
endmodule

@@ sv/npcg_matrix.sv @@
// ----------------------------------------------------------------------------
// npcg_matrix
// Chroma scaling and decoder matrix to 8-bit RGB, two registered stages.
// ----------------------------------------------------------------------------
module npcg_matrix (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [npcg_pkg::SAT_W-1:0]    saturation,
   input  npcg_pkg::cell_data_type       data_in,
   output logic [7:0]                    red,
   output logic [7:0]                    green,
   output logic [7:0]                    blue
);
   import npcg_pkg::*;

   logic signed [33:0] xr;
   logic signed [33:0] yr;
   logic signed [18:0] cs_w;
   logic signed [18:0] sn_w;
   logic signed [28:0] cm;
   logic signed [28:0] sm;
   logic signed [20:0] s_in;
   logic signed [20:0] c_in;
   logic signed [20:0] s_ff;
   logic signed [20:0] c_ff;
   logic [14:0] yl_in;
   logic [14:0] yl_ff;
   logic signed [31:0] rn;
   logic signed [31:0] bn;
   logic signed [31:0] gn;
   logic signed [31:0] gq;
   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;

   function automatic logic [7:0] clamp(input logic signed [31:0] q);
      logic [7:0] v;
      if (q < 0) v = 8'd0;
      else if (q > 32'sd255) v = 8'd255;
      else v = q[7:0];
      return v;
   endfunction

   always_comb begin
      xr = (data_in.x + 34'sd32768) >>> 16;
      yr = (data_in.y + 34'sd32768) >>> 16;
      cs_w = data_in.flip ? -xr[18:0] : xr[18:0];
      sn_w = data_in.flip ? -yr[18:0] : yr[18:0];
      cm = cs_w * $signed({1'b0, saturation});
      sm = sn_w * $signed({1'b0, saturation});
      yl_in = luma_value(data_in.kind, data_in.row);
      if (data_in.kind == KIND_HUED) begin
         c_in = cm[28:8];
         s_in = sm[28:8];
      end else begin
         c_in = 21'sd0;
         s_in = 21'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s_ff  <= s_in;
         c_ff  <= c_in;
         yl_ff <= yl_in;
      end
   end

   always_comb begin
      rn = (32'($signed({1'b0, yl_ff})) + 32'(s_ff)) >>> 6;
      bn = (32'($signed({1'b0, yl_ff})) - 32'(c_ff)) >>> 6;
      gn = 32'sd53 * 32'($signed({1'b0, yl_ff})) - 32'sd27 * 32'(s_ff)
         + 32'sd10 * 32'(c_ff);
      // floor division by 3392: shift by 6, then floor divide by 53
      gq = gn >>> 6;
      if (gq < 0) gq = -32'sd1;
      else gq = 32'((64'(gq) * 64'sd79139) >>> 22);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         red_ff   <= clamp(rn);
         green_ff <= clamp(gq);
         blue_ff  <= clamp(bn);
      end
   end

   assign red = red_ff;
   assign green = green_ff;
   assign blue = blue_ff;
endmodule

@@ sv/ntsc_palette_color_generator_unit.sv @@
// ----------------------------------------------------------------------------
// ntsc_palette_color_generator_unit
// Color code to RGB palette generator: one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one color code per clock while the output is free or taken. Its RGB
// value passes through the angle mapping register, the row of rotation cells
// (one per iteration, at most 20) and the two matrix stages, the second of
// which is the output register. The whole pipe advances when the output is
// free or taken.
module ntsc_palette_color_generator_unit #(
   parameter int CORDIC_ITERATIONS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [0:0]                  csr_index,
   input  logic [npcg_pkg::CSR_W-1:0]  csr_write_data,
   npcg_stream_if.sink                 req,
   npcg_stream_if.source               rsp
);
   import npcg_pkg::*;

   localparam int NCELL = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;
   localparam int DEPTH = NCELL + 3;

   logic [HUE_W-1:0] hue_offset_ff;
   logic [SAT_W-1:0] saturation_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic             advance;
   logic [CODE_W-1:0] code;
   logic [3:0]        hue;
   logic [14:0]       ang_sum;
   logic [13:0]       ang_mod;
   logic [45:0]       ang_prod;
   logic [28:0]       frac_prod;
   logic [31:0]       bang;
   logic              flip;
   cell_data_type     entry_in;
   cell_data_type     entry_ff;
   cell_data_type     chain [NCELL+1];
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = valid_ff[DEPTH-1];
   assign rsp.data = {red, green, blue};

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_offset_ff <= HUE_W'(5312);
         saturation_ff <= SAT_W'(128);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_HUE_OFFSET: hue_offset_ff <= csr_write_data[HUE_W-1:0];
            CSR_SATURATION: saturation_ff <= csr_write_data[SAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= valid_in;
   end

   // Angle: (9 - hue) * 480 + offset, reduced modulo 5760 (offset < 8192).
   always_comb begin
      code = req.data;
      hue = code[3:0];
      ang_sum = 15'(hue_offset_ff) + 15'(ANGLE_MOD) + 15'(4320) - 15'(hue) * 15'd480;
      if (ang_sum >= 15'(3 * ANGLE_MOD)) ang_mod = 14'(ang_sum - 15'(3 * ANGLE_MOD));
      else if (ang_sum >= 15'(2 * ANGLE_MOD)) ang_mod = 14'(ang_sum - 15'(2 * ANGLE_MOD));
      else if (ang_sum >= 15'(ANGLE_MOD)) ang_mod = 14'(ang_sum - 15'(ANGLE_MOD));
      else ang_mod = 14'(ang_sum);
      entry_in.row = code[5:4];
      priority if (hue > 4'd13) entry_in.kind = KIND_BLACK;
      else if (hue == 4'd13) entry_in.kind = KIND_GRAYD;
      else if (hue == 4'd0) entry_in.kind = KIND_GRAY0;
      else entry_in.kind = KIND_HUED;
      entry_in.x = 34'sd0;
      entry_in.y = 34'sd0;
      entry_in.z = 34'(ang_mod);
      entry_in.flip = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (advance) entry_ff <= entry_in;
   end

   // floor(a * 2^32 / 5760) = a * 745654 + floor(2a / 45), the last by reciprocal
   always_comb begin
      ang_prod = 46'(entry_ff.z[12:0]) * 46'd745654;
      frac_prod = 29'({entry_ff.z[12:0], 1'b0}) * 29'd23302;
      bang = 32'(ang_prod) + 32'(frac_prod[28:20]);
      flip = (bang[31:30] == 2'd1) || (bang[31:30] == 2'd2);
      chain[0] = entry_ff;
      chain[0].flip = flip;
      chain[0].x = 34'sd652032874;
      chain[0].y = 34'sd0;
      chain[0].z = 34'($signed(flip ? (bang ^ 32'h8000_0000) : bang));
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      npcg_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .enable   (advance),
         .data_in  (chain[i]),
         .data_out (chain[i+1])
      );
   end

   npcg_matrix u_matrix (
      .clock      (clock),
      .enable     (advance),
      .saturation (saturation_ff),
      .data_in    (chain[NCELL]),
      .red        (red),
      .green      (green),
      .blue       (blue)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("request refused with empty output");
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !$isunknown(rsp.data))
      else $error("unknown result data");
endmodule

@@ dv/ntsc_palette_color_generator_unit_checker.sv @@
// ----------------------------------------------------------------------------
// ntsc_palette_color_generator_unit_checker
// Watches the request, response and register ports of the palette generator,
// predicts the RGB value of every accepted color code and compares it with
// the responses in order.
// ----------------------------------------------------------------------------
module ntsc_palette_color_generator_unit_checker #(
   parameter int CORDIC_ITERATIONS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [0:0]                 csr_index,
   input  logic [npcg_pkg::CSR_W-1:0] csr_write_data,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [5:0]                 req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [23:0]                rsp_data,
   output int                         failures,
   output int                         pending
);
   import npcg_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   localparam longint ARC_STEP [20] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41721,
      20860, 10430, 5215, 2607, 1303};
   localparam longint LUMA_GRAY0 [4] = '{8192, 12288, 16384, 16384};
   localparam longint LUMA_HUED  [4] = '{4751, 7373, 11960, 14746};
   localparam longint LUMA_GRAYD [4] = '{0, 3932, 7700, 12616};

   logic [12:0] hue_offset;
   logic [8:0]  saturation;
   rgb_type     expected_colors[$];

   function automatic longint floor_div(longint n, longint d);
      if (n >= 0) return n / d;
      return -(((-n) + d - 1) / d);
   endfunction

   function automatic logic [7:0] clamp_byte(longint n, longint d);
      longint q;
      q = floor_div(n, d);
      if (q < 0) return 8'd0;
      if (q > 255) return 8'd255;
      return q[7:0];
   endfunction

   function automatic void rotate_angle(input longint a, output longint sn,
                                        output longint cs);
      longint unsigned wide;
      logic [31:0] ang;
      logic flip;
      longint x, y, zr, dx, dy;
      wide = (longint'(a) << 32) / 5760;
      ang = wide[31:0];
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang ^ 32'h8000_0000;
      zr = ang[31] ? longint'(ang) - 64'sd4294967296 : longint'(ang);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_ITERATIONS && i < 20; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (zr >= 0) begin
            x -= dx; y += dy; zr -= ARC_STEP[i];
         end else begin
            x += dx; y -= dy; zr += ARC_STEP[i];
         end
      end
      x = (x + 32768) >>> 16;
      y = (y + 32768) >>> 16;
      if (flip) begin
         x = -x;
         y = -y;
      end
      sn = y;
      cs = x;
   endfunction

   function automatic rgb_type palette_color(logic [5:0] code);
      rgb_type c;
      int row, hue;
      longint a, sn, cs, s, k, yl;
      row = code[5:4];
      hue = code[3:0];
      if (hue > 13) begin
         c = '0;
      end else if (hue == 13) begin
         c.red = clamp_byte(LUMA_GRAYD[row], 64);
         c.green = c.red; c.blue = c.red;
      end else if (hue == 0) begin
         c.red = clamp_byte(LUMA_GRAY0[row], 64);
         c.green = c.red; c.blue = c.red;
      end else begin
         a = ((9 - hue) * 480 + longint'(hue_offset) + 5760) % 5760;
         rotate_angle(a, sn, cs);
         yl = LUMA_HUED[row];
         s = (sn * longint'(saturation)) >>> 8;
         k = (cs * longint'(saturation)) >>> 8;
         c.red = clamp_byte(yl + s, 64);
         c.green = clamp_byte(53 * yl - 27 * s + 10 * k, 53 * 64);
         c.blue = clamp_byte(yl - k, 64);
      end
      return c;
   endfunction

   assign pending = expected_colors.size();

   always @(posedge clock) begin
      rgb_type got, want;
      if (reset) begin
         hue_offset <= 13'd5312;
         saturation <= 9'd128;
         expected_colors.delete();
         failures <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_HUE_OFFSET) hue_offset <= csr_write_data;
            else saturation <= csr_write_data[8:0];
         end
         if (req_valid && req_ready) expected_colors.push_back(palette_color(req_data));
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_colors.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               failures <= failures + 1;
            end else begin
               want = expected_colors.pop_front();
               if (got != want) begin
                  $display("%0t: rgb mismatch expected %h actual %h", $time, want, got);
                  failures <= failures + 1;
               end
            end
         end
      end
   end
endmodule

@@ dv/ntsc_palette_color_generator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ntsc_palette_color_generator_unit_tb
// Drives color codes through the palette generator under several hue and
// saturation settings with random stalls on both sides; the checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module ntsc_palette_color_generator_unit_tb;
   import npcg_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = 1'b0;
   logic [CSR_W-1:0] csr_write_data = '0;
   logic quiet = 1'b0;
   int   failures, pending;
   int   stall_left = 0;
   int   idle_cycles = 0;

   npcg_stream_if #(.WIDTH(CODE_W)) req_if ();
   npcg_stream_if #(.WIDTH(24))     rsp_if ();

   ntsc_palette_color_generator_unit i_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .req(req_if), .rsp(rsp_if));

   ntsc_palette_color_generator_unit_checker i_checker (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_data(req_if.data),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_data(rsp_if.data),
      .failures(failures), .pending(pending));

   always #1 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= $urandom_range(1, 19) - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_code(logic [5:0] code);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.data = code;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin
      logic [12:0] hues [7] = '{13'd0, 13'd5759, 13'd8191, 13'd0, 13'd2880, 13'd7000, 13'd0};
      logic [12:0] sats [7] = '{13'd0, 13'd256, 13'd511, 13'd256, 13'd200, 13'd300, 13'd0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int r = 0; r < 4; r++) begin
         send_code({r[1:0], 4'd0});
         send_code({r[1:0], 4'd13});
         send_code({r[1:0], 4'd14});
         send_code({r[1:0], 4'd15});
      end
      for (int h = 1; h <= 12; h++) send_code({h[1:0], h[3:0]});
      drain();
      for (int p = 0; p < 7; p++) begin
         if (p == 6) begin
            hues[p] = 13'($urandom_range(0, 8191));
            sats[p] = 13'($urandom_range(0, 511));
            quiet = 1'b1;
         end
         write_csr(CSR_HUE_OFFSET, hues[p]);
         write_csr(CSR_SATURATION, sats[p]);
         repeat (150) send_code(6'($urandom_range(0, 63)));
         drain();
      end
      if (failures == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

@@ files.f @@
sv/npcg_pkg.sv
sv/npcg_stream_if.sv
sv/npcg_cordic_cell.sv
sv/npcg_matrix.sv
sv/ntsc_palette_color_generator_unit.sv
dv/ntsc_palette_color_generator_unit_checker.sv
dv/ntsc_palette_color_generator_unit_tb.sv
